// File: rtl/b64e_pkg.sv
`timescale 1ns / 1ps

package b64e_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_LOWER = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT = 6'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_run;
    } t_out_item;

    // Characters produced by one input byte, emitted from index 0 up to last_idx.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < SEXTET_LOWER) begin
            return CH_UPPER_A + w;
        end else if (v < SEXTET_DIGIT) begin
            return CH_LOWER_A + w - {2'b00, SEXTET_LOWER};
        end else if (v < SEXTET_PLUS) begin
            return CH_DIGIT_0 + w - {2'b00, SEXTET_DIGIT};
        end else if (v == SEXTET_PLUS) begin
            return CH_PLUS;
        end else begin
            return CH_SLASH;
        end
    endfunction

endpackage

// File: rtl/b64e_front.sv
`timescale 1ns / 1ps

module b64e_front
    import b64e_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_full,
    output logic     o_q_wr,
    output t_job     o_q_job
);

    typedef enum logic [1:0] {
        POS_0,
        POS_1,
        POS_2
    } t_pos;

    t_pos       r_pos, n_pos;
    logic [3:0] r_carry, n_carry;
    logic       accept;
    logic [7:0] b;

    assign b       = i_item.data_byte;
    assign accept  = i_push && !i_q_full;
    assign o_full  = i_q_full;
    assign o_q_wr  = accept;

    always_comb begin
        o_q_job.chars    = {4{CH_PAD}};
        o_q_job.last_idx = 2'd0;
        n_pos            = r_pos;
        n_carry          = r_carry;
        case (r_pos)
            POS_1: begin
                o_q_job.chars[0] = b64_char({r_carry[1:0], b[7:4]});
                o_q_job.chars[1] = b64_char({b[3:0], 2'b00});
                o_q_job.last_idx = i_item.is_final ? 2'd2 : 2'd0;
                n_pos            = POS_2;
                n_carry          = b[3:0];
            end
            POS_2: begin
                o_q_job.chars[0] = b64_char({r_carry, b[7:6]});
                o_q_job.chars[1] = b64_char(b[5:0]);
                o_q_job.last_idx = 2'd1;
                n_pos            = POS_0;
                n_carry          = 4'd0;
            end
            default: begin
                o_q_job.chars[0] = b64_char(b[7:2]);
                o_q_job.chars[1] = b64_char({b[1:0], 4'b0000});
                o_q_job.last_idx = i_item.is_final ? 2'd3 : 2'd0;
                n_pos            = POS_1;
                n_carry          = {2'b00, b[1:0]};
            end
        endcase
        // a final byte closes the group
        if (i_item.is_final) begin
            n_pos   = POS_0;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_0;
            r_carry <= 4'd0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_carry <= n_carry;
        end
    end

`ifndef SYNTH
    a_final_restarts_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.is_final) |=> (r_pos == POS_0 && r_carry == 4'd0))
        else $error("group not restarted after final byte");
    a_carry_narrow_at_pos1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_1) |-> (r_carry[3:2] == 2'b00))
        else $error("carry too wide after first byte of group");
    a_carry_zero_at_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_0) |-> (r_carry == 4'd0))
        else $error("carry left over at group start");
`endif

endmodule

// File: rtl/b64e_queue.sv
`timescale 1ns / 1ps

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_job,
    input  logic i_rd,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job queue count out of range");
    a_ptrs_meet_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("job queue pointers disagree with count");
    a_write_only_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("job queue lost a write");
`endif

endmodule

// File: rtl/b64e_back.sv
`timescale 1ns / 1ps

module b64e_back
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_head,
    output logic      o_q_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       advance;
    logic       emit;
    logic       last_char;

    assign advance   = !r_out_valid || i_pop;
    assign emit      = advance && i_q_valid;
    assign last_char = (r_idx == i_q_head.last_idx);
    assign o_q_rd    = emit && last_char;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_char   <= i_q_head.chars[r_idx];
            r_out.end_of_run <= last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= i_q_valid;
            end
            if (emit) begin
                r_idx <= last_char ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

`ifndef SYNTH
    a_idx_within_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx <= i_q_head.last_idx))
        else $error("character index past end of job");
    a_idx_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_rd |=> (r_idx == 2'd0))
        else $error("character index not restarted after job");
    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_idx == 2'd0))
        else $error("character index stale with no job");
`endif

endmodule

// File: rtl/base64_stream_encoder.sv
`timescale 1ns / 1ps

// Base64 (RFC 4648) stream encoder. Push one message byte per transfer, with
// is_final set on the last byte of the message; pop ASCII characters, one per
// transfer, with end_of_run marking the last character a byte produces. A byte
// produces one or two characters, and a final byte produces two to four
// including '=' padding. Characters leave at one per cycle from the output
// register while the consumer keeps popping, and a byte yields 1 to 4 of them
// (4/3 on average over a long message). Bytes are taken one per cycle into a
// job queue of QDEPTH entries; push stalls (full) only when that queue fills.
// A byte's first character passes through the job queue and then the output
// register before it reaches the result ports, where it can be popped.
module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int QDEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic q_wr;
    t_job q_wr_job;
    logic q_full;
    logic q_valid;
    t_job q_head;
    logic q_rd;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in_item),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_wr   (q_wr),
        .o_q_job  (q_wr_job)
    );

    b64e_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_job (q_wr_job),
        .i_rd     (q_rd),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule
